>>> hw/rtl/ktl_pkg.sv
// Shared types, constants and the keyword table of the keyword trie lexer.
// No dependencies; ktl_front, ktl_cmdq, ktl_back and the top level import it.
package ktl_pkg;

    localparam int KTL_MAX_IDENT_LEN = 32;
    localparam int LEN_W             = 6;
    localparam int KW_COUNT          = 34;
    localparam int KW_MAXLEN         = 10;

    typedef logic [5:0]          kind_t;
    typedef logic [KW_COUNT-1:0] kw_mask_t;

    localparam kind_t KIND_ERROR = 6'd0;
    localparam kind_t KIND_EOF   = 6'd1;
    localparam kind_t KIND_IDENT = 6'd2;
    localparam kind_t KIND_INT   = 6'd3;

    // Keyword text, right justified: the first character sits highest.
    localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_COUNT] = '{
        "True", "False", "None", "if", "else", "while", "for", "foreach", "do",
        "continue", "break", "try", "catch", "return", "yield", "function",
        "static", "abstract", "private", "protected", "class", "include",
        "{", "}", "(", ")", ";", "==", "!=", "<", ">", "<=", ">=", "+"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd5, 4'd4, 4'd2, 4'd4, 4'd5, 4'd3, 4'd7, 4'd2, 4'd8, 4'd5, 4'd3,
        4'd5, 4'd6, 4'd5, 4'd8, 4'd6, 4'd8, 4'd7, 4'd9, 4'd5, 4'd7, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd1, 4'd1, 4'd2, 4'd2, 4'd1
    };

    localparam kind_t KW_KIND [KW_COUNT] = '{
        6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14,
        6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
        6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd31, 6'd32, 6'd33,
        6'd31, 6'd34, 6'd35
    };

    // Character i of keyword k, zero past its end.
    function automatic logic [7:0] kw_char(int k, logic [3:0] i);
        int sh;
        sh = (int'(KW_LEN[k]) - 1 - int'(i)) * 8;
        if (i < KW_LEN[k])
            return 8'(KW_TEXT[k] >> sh);
        return 8'd0;
    endfunction

    // One queued command: a single token, or a run read from the buffer.
    typedef struct packed {
        kind_t             kind;
        logic [63:0]       value;
        logic              run;
        logic [LEN_W-1:0]  len;
        logic              bank;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic v0;
        logic v1;
        cmd_t c0;
        cmd_t c1;
    } push_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [LEN_W-1:0] idx;
        logic [7:0]       data;
    } buf_wr_t;

endpackage

>>> hw/rtl/ktl_ifs.sv
// Handshake interfaces of the keyword trie lexer: source bytes and tokens.
// No dependencies.
interface ktl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;
    modport source (output valid, char_in, end_of_input, input ready);
    modport sink   (input valid, char_in, end_of_input, output ready);
endinterface

interface ktl_token_if;
    logic               valid;
    logic               ready;
    logic [5:0]         token_kind;
    logic signed [63:0] int_value;
    logic [7:0]         ident_char;
    logic               run_last;
    modport source (output valid, token_kind, int_value, ident_char, run_last,
                    input ready);
    modport sink   (input valid, token_kind, int_value, ident_char, run_last,
                    output ready);
endinterface

>>> hw/rtl/ktl_front.sv
// Front end of the lexer: takes bytes, walks the keyword trie and the
// number and identifier modes, and pushes commands. Uses ktl_pkg, ktl_ifs.
module ktl_front import ktl_pkg::*; #(
    parameter int MAX_IDENT_LEN = KTL_MAX_IDENT_LEN
) (
    input  logic        clk,
    input  logic        rst_n,
    ktl_char_if.sink    chars,
    input  logic        q_room,
    input  logic        run_done,
    output push_t       push,
    output buf_wr_t     buf_wr
);

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_COMMENT, MODE_TRIE, MODE_IDENT, MODE_NUMBER
    } mode_t;

    typedef enum logic [1:0] {BASE_DEC, BASE_HEX, BASE_BIN} base_t;

    localparam logic [7:0] CH_NL   = 8'd10;
    localparam logic [7:0] CH_NUL  = 8'd0;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_UND  = 8'h5f;
    localparam logic [7:0] CH_MAX  = 8'd127;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_IDENT_LEN);

    function automatic logic is_digit(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h61:8'h7a], [8'h41:8'h5a], CH_UND};
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c inside {8'h20, [8'd9:8'd13]};
    endfunction

    mode_t            mode_reg, mode_next;
    base_t            base_reg, base_next;
    kw_mask_t         alive_reg, alive_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             alnum_reg, alnum_next;
    logic             lz_reg, lz_next;
    logic [63:0]      acc_reg, acc_next;
    logic             bank_reg, bank_next;
    logic             busy_reg, busy_next;

    kw_mask_t    cand, rcand;
    logic        found, rfound;
    kind_t       nk;
    cmd_t        fin;
    logic        fin_v;
    logic        accept;
    logic        do_fin, go_idle, num_done, err_v;
    logic [3:0]  dig;
    logic        dig_ok;
    logic [7:0]  c;
    mode_t       m;

    assign c           = chars.char_in;
    assign chars.ready = !busy_reg && q_room;
    assign accept      = chars.valid && chars.ready;

    // Trie step: every keyword still on the path that continues with c.
    always_comb
    begin
        nk = KIND_ERROR;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            cand[k]  = alive_reg[k] && (LEN_W'(KW_LEN[k]) > len_reg) &&
                       (kw_char(k, len_reg[3:0]) == c);
            rcand[k] = (kw_char(k, 4'd0) == c);
        end
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (alive_reg[k] && LEN_W'(KW_LEN[k]) == len_reg)
                nk = KW_KIND[k];
        end
        found  = |cand;
        rfound = |rcand;
    end

    always_comb
    begin
        dig_ok = 1'b0;
        dig    = 4'd0;
        if (base_reg == BASE_BIN)
        begin
            dig_ok = (c == 8'h30) || (c == 8'h31);
            dig    = c[3:0];
        end
        else if (is_digit(c))
        begin
            dig_ok = 1'b1;
            dig    = c[3:0];
        end
        else if (base_reg == BASE_HEX && (c inside {[8'h61:8'h66], [8'h41:8'h46]}))
        begin
            dig_ok = 1'b1;
            dig    = 4'(c[3:0] + 4'd9);
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        base_next  = base_reg;
        alive_next = alive_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        alnum_next = alnum_reg;
        lz_next    = lz_reg;
        acc_next   = acc_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg && !run_done;
        push       = '0;
        buf_wr     = '0;
        do_fin     = 1'b0;
        go_idle    = 1'b0;
        num_done   = 1'b0;
        err_v      = 1'b0;
        m          = mode_reg;

        // Token that a finish of the pending state gives.
        fin   = '0;
        fin_v = 1'b0;
        case (mode_reg)
            MODE_TRIE, MODE_IDENT:
            begin
                fin_v = 1'b1;
                if (mode_reg == MODE_TRIE && nk != KIND_ERROR)
                    fin.kind = nk;
                else if (mode_reg == MODE_IDENT || alnum_reg)
                begin
                    fin.kind = ovf_reg ? KIND_ERROR : KIND_IDENT;
                    fin.run  = 1'b1;
                    fin.len  = len_reg;
                    fin.bank = bank_reg;
                end
                else
                    fin.kind = KIND_ERROR;
            end
            MODE_NUMBER:
            begin
                fin_v      = 1'b1;
                fin.kind   = KIND_INT;
                fin.value  = acc_reg;
            end
            default:
            begin
                fin_v = 1'b0;
            end
        endcase

        if (accept)
        begin
            if (chars.end_of_input)
                do_fin = 1'b1;
            else
            begin
                if (m == MODE_TRIE)
                begin
                    if (c <= CH_MAX && found)
                    begin
                        if (len_reg < LEN_MAX)
                        begin
                            buf_wr   = '{1'b1, bank_reg, len_reg, c};
                            len_next = len_reg + 1'b1;
                        end
                        else
                            ovf_next = 1'b1;
                        alnum_next = alnum_reg && is_word(c);
                        alive_next = cand;
                    end
                    else if (nk == KIND_ERROR && alnum_reg)
                        m = MODE_IDENT;
                    else
                    begin
                        do_fin  = 1'b1;
                        go_idle = 1'b1;
                    end
                end

                if (m == MODE_IDENT)
                begin
                    if (is_word(c))
                    begin
                        if (len_reg < LEN_MAX)
                        begin
                            buf_wr   = '{1'b1, bank_reg, len_reg, c};
                            len_next = len_reg + 1'b1;
                        end
                        else
                            ovf_next = 1'b1;
                        mode_next = MODE_IDENT;
                    end
                    else
                    begin
                        do_fin  = 1'b1;
                        go_idle = 1'b1;
                    end
                end
                else if (m == MODE_NUMBER)
                begin
                    if (lz_reg && base_reg == BASE_DEC)
                    begin
                        if (c == CH_X)
                        begin
                            base_next = BASE_HEX;
                            num_done  = 1'b1;
                        end
                        else if (c == CH_B)
                        begin
                            base_next = BASE_BIN;
                            num_done  = 1'b1;
                        end
                    end
                    lz_next = 1'b0;
                    if (!num_done)
                    begin
                        if (dig_ok)
                        begin
                            if (base_reg == BASE_HEX)
                                acc_next = {acc_reg[59:0], dig};
                            else if (base_reg == BASE_BIN)
                                acc_next = {acc_reg[62:0], dig[0]};
                            else
                                acc_next = {acc_reg[60:0], 3'b000} +
                                           {acc_reg[62:0], 1'b0} + 64'(dig);
                        end
                        else
                        begin
                            do_fin  = 1'b1;
                            go_idle = 1'b1;
                        end
                    end
                end
                else if (m == MODE_COMMENT)
                begin
                    if (c == CH_NL || c == CH_NUL)
                        mode_next = MODE_IDLE;
                end
                else if (m == MODE_IDLE)
                    go_idle = 1'b1;
            end

            if (do_fin)
            begin
                mode_next  = MODE_IDLE;
                base_next  = BASE_DEC;
                alive_next = '1;
                len_next   = '0;
                ovf_next   = 1'b0;
                alnum_next = 1'b1;
                lz_next    = 1'b0;
                acc_next   = '0;
                if (fin_v)
                begin
                    push.v0 = 1'b1;
                    push.c0 = fin;
                    if (fin.run)
                    begin
                        bank_next = !bank_reg;
                        busy_next = 1'b1;
                    end
                end
            end

            if (go_idle)
            begin
                if (c == CH_NUL || is_space(c))
                    mode_next = MODE_IDLE;
                else if (c == CH_HASH)
                    mode_next = MODE_COMMENT;
                else if (is_digit(c))
                begin
                    mode_next = MODE_NUMBER;
                    acc_next  = 64'(c - CH_ZERO);
                    lz_next   = (c == CH_ZERO);
                end
                else if (c > CH_MAX)
                    err_v = 1'b1;
                else if (rfound || is_word(c))
                begin
                    mode_next  = rfound ? MODE_TRIE : MODE_IDENT;
                    buf_wr     = '{1'b1, bank_next, '0, c};
                    len_next   = LEN_W'(1);
                    alnum_next = is_word(c);
                    alive_next = rcand;
                end
                else
                    err_v = 1'b1;
            end

            if (err_v || chars.end_of_input)
            begin
                if (push.v0)
                begin
                    push.v1      = 1'b1;
                    push.c1.kind = err_v ? KIND_ERROR : KIND_EOF;
                end
                else
                begin
                    push.v0      = 1'b1;
                    push.c0.kind = err_v ? KIND_ERROR : KIND_EOF;
                end
            end

            if (push.v1)
                push.c1.last = 1'b1;
            else if (push.v0)
                push.c0.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            base_reg  <= BASE_DEC;
            alive_reg <= '1;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            alnum_reg <= 1'b1;
            lz_reg    <= 1'b0;
            acc_reg   <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            base_reg  <= base_next;
            alive_reg <= alive_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            alnum_reg <= alnum_next;
            lz_reg    <= lz_next;
            acc_reg   <= acc_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

>>> hw/rtl/ktl_cmdq.sv
// Four-entry command queue between the lexer front and back ends.
// Takes up to two commands a cycle and hands out one. Uses ktl_pkg.
module ktl_cmdq import ktl_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  pop,
    output logic  room,
    output logic  head_v,
    output cmd_t  head
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    cmd_t          q_reg [DEPTH];
    logic [PW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic [PW-1:0] wp1;

    assign wp1    = wp_reg + 1'b1;
    assign room   = cnt_reg <= (PW+1)'(DEPTH - 2);
    assign head_v = cnt_reg != '0;
    assign head   = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg + PW'(push.v0) + PW'(push.v1);
        rp_next  = rp_reg + PW'(pop);
        cnt_next = cnt_reg + (PW+1)'(push.v0) + (PW+1)'(push.v1) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
            q_reg[wp_reg] <= push.c0;
        if (push.v1)
            q_reg[wp1] <= push.c1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/ktl_back.sv
// Back end of the lexer: turns queued commands into tokens, reading
// identifier runs from the two-bank character buffer. Uses ktl_pkg, ktl_ifs.
module ktl_back import ktl_pkg::*; #(
    parameter int MAX_IDENT_LEN = KTL_MAX_IDENT_LEN
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_v,
    input  cmd_t        head,
    input  buf_wr_t     buf_wr,
    output logic        pop,
    output logic        run_done,
    ktl_token_if.source tokens
);

    localparam int IDX_W = $clog2(MAX_IDENT_LEN);

    typedef enum logic [1:0] {B_IDLE, B_RD, B_OUT} bstate_t;

    logic [7:0]       mem [2][MAX_IDENT_LEN];
    logic [7:0]       rd_data_reg;
    bstate_t          state_reg;
    logic [LEN_W-1:0] idx_reg;
    logic             out_v_reg;
    kind_t            kind_reg;
    logic [63:0]      value_reg;
    logic [7:0]       char_reg;
    logic             last_reg;
    logic             out_free;
    logic             end_char;

    assign out_free = !out_v_reg || tokens.ready;
    assign end_char = (idx_reg == head.len - 1'b1);
    assign pop      = head_v && out_free &&
                      ((state_reg == B_IDLE && !head.run) ||
                       (state_reg == B_OUT && end_char));
    assign run_done = pop && head.run;

    assign tokens.valid      = out_v_reg;
    assign tokens.token_kind = kind_reg;
    assign tokens.int_value  = value_reg;
    assign tokens.ident_char = char_reg;
    assign tokens.run_last   = last_reg;

    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
            mem[buf_wr.bank][buf_wr.idx[IDX_W-1:0]] <= buf_wr.data;
        rd_data_reg <= mem[head.bank][idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
            out_v_reg <= 1'b0;
            kind_reg  <= KIND_ERROR;
            value_reg <= '0;
            char_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (out_v_reg && tokens.ready)
                out_v_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (head_v && out_free)
                    begin
                        if (head.run)
                        begin
                            idx_reg   <= '0;
                            state_reg <= B_RD;
                        end
                        else
                        begin
                            out_v_reg <= 1'b1;
                            kind_reg  <= head.kind;
                            value_reg <= head.value;
                            char_reg  <= '0;
                            last_reg  <= head.last;
                        end
                    end
                end
                B_RD:
                begin
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        out_v_reg <= 1'b1;
                        kind_reg  <= head.kind;
                        value_reg <= '0;
                        char_reg  <= rd_data_reg;
                        last_reg  <= end_char && head.last;
                        if (end_char)
                            state_reg <= B_IDLE;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= B_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_run_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE) |-> (head_v && head.run))
        else $error("run in progress without a run command at the queue head");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE) |-> (head.len != '0 && idx_reg < head.len))
        else $error("identifier run index out of range");

    a_single_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head.run) |=> (out_v_reg && value_reg == $past(head.value)))
        else $error("popped token did not reach the output register");

endmodule

>>> hw/rtl/keyword_trie_lexer.sv
// Top level of the keyword trie lexer: front end, command queue, back end.
// Uses ktl_pkg, ktl_ifs, ktl_front, ktl_cmdq and ktl_back.
//
//   Channel  Direction  Payload                                      Handshake
//   chars    in         char_in[8], end_of_input[1]                  valid/ready
//   tokens   out        token_kind[6], int_value[64] signed,         valid/ready
//                       ident_char[8], run_last[1]
//
// A byte that causes at most one plain token is taken every cycle while the
// four-entry queue has room for two commands. A byte that ends an identifier
// stops intake until the run is out: the back end reads the character buffer
// one entry at a time, through a read state and then an output state for each
// character. Reset is asynchronous and active low and leaves the lexer
// between tokens; it needs no clearing pass. Either side may stall at any
// time; the output register keeps its token.
module keyword_trie_lexer import ktl_pkg::*; #(
    parameter int MAX_IDENT_LEN = KTL_MAX_IDENT_LEN
) (
    input  logic        clk,
    input  logic        rst_n,
    ktl_char_if.sink    chars,
    ktl_token_if.source tokens
);

    // Commands travel from front to back through the queue; the front also
    // writes identifier characters into the back end's buffer, into the bank
    // that no pending run reads.
    push_t   push;
    buf_wr_t buf_wr;
    logic    q_room;
    logic    pop;
    logic    run_done;
    logic    head_v;
    cmd_t    head;

    ktl_front #(.MAX_IDENT_LEN(MAX_IDENT_LEN)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .q_room   (q_room),
        .run_done (run_done),
        .push     (push),
        .buf_wr   (buf_wr)
    );

    ktl_cmdq u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .room   (q_room),
        .head_v (head_v),
        .head   (head)
    );

    ktl_back #(.MAX_IDENT_LEN(MAX_IDENT_LEN)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_v   (head_v),
        .head     (head),
        .buf_wr   (buf_wr),
        .pop      (pop),
        .run_done (run_done),
        .tokens   (tokens)
    );

endmodule
